// File: rtl/flash_record_log_slot_manager_defines.svh
// Assertion macros shared by the slot manager RTL.
`ifndef FLASH_RECORD_LOG_SLOT_MANAGER_DEFINES_SVH
`define FLASH_RECORD_LOG_SLOT_MANAGER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define FRLSM_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FRLSM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/frlsm_pkg.sv
// Request, status and command codes and sizing defaults for the slot manager.
package frlsm_pkg;

   localparam int SLOTS_PER_PAGE_DEFAULT = 3;
   localparam int PAGE_COUNT = 2;

   localparam logic [2:0] REQ_SCAN    = 3'd0;
   localparam logic [2:0] REQ_RESOLVE = 3'd1;
   localparam logic [2:0] REQ_SAVE    = 3'd2;
   localparam logic [2:0] REQ_COMMIT  = 3'd3;
   localparam logic [2:0] REQ_ERASED  = 3'd4;
   localparam logic [2:0] REQ_COMPACT = 3'd5;

   localparam logic [3:0] ST_DONE      = 4'd0;
   localparam logic [3:0] ST_CURRENT   = 4'd1;
   localparam logic [3:0] ST_EMPTY     = 4'd2;
   localparam logic [3:0] ST_CORRUPT   = 4'd3;
   localparam logic [3:0] ST_STALE     = 4'd4;
   localparam logic [3:0] ST_UNCHANGED = 4'd5;
   localparam logic [3:0] ST_FULL      = 4'd6;
   localparam logic [3:0] ST_PROGRAM   = 4'd7;
   localparam logic [3:0] ST_WRITTEN   = 4'd8;
   localparam logic [3:0] ST_FAILED    = 4'd9;

   localparam logic [1:0] CMD_NONE    = 2'd0;
   localparam logic [1:0] CMD_ERASE   = 2'd1;
   localparam logic [1:0] CMD_PROGRAM = 2'd2;

endpackage

// File: rtl/flash_record_log_slot_manager.sv
// Slot manager for a two-page flash record log: slot table, resolve, save and compaction.
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+-------------------------------------
//  request  | start, busy, req_*            | taken when start=1 and busy=0
//  result   | rsp_valid, rsp_*              | one-cycle strobe, rsp_last ends item
//
// Scan, commit and an unchanged save answer in the cycle after the item is taken.
// Resolve and compaction walk every slot, one slot a cycle; save walks up to
// every slot; page erase walks SLOTS_PER_PAGE_N slots.
// Compaction then issues up to three results on consecutive cycles.
// Synchronous active-high reset marks every slot erased and clears the record.
// Results cannot be stalled; busy stays high while a walk or plan runs.
`include "flash_record_log_slot_manager_defines.svh"

module flash_record_log_slot_manager
   import frlsm_pkg::*;
#(
   parameter int SLOTS_PER_PAGE_N = SLOTS_PER_PAGE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_slot_index,
   input  logic        req_is_erased,
   input  logic        req_is_valid,
   input  logic        req_has_magic,
   input  logic        req_version_match,
   input  logic [31:0] req_seq_in,
   input  logic        req_same_as_current,
   input  logic        req_write_ok,
   input  logic        req_page_index,
   output logic        rsp_valid,
   output logic [3:0]  rsp_status,
   output logic [1:0]  rsp_command,
   output logic [2:0]  rsp_slot_out,
   output logic        rsp_page_out,
   output logic [31:0] rsp_seq_out,
   output logic [2:0]  rsp_free_count,
   output logic        rsp_needs_compact,
   output logic        rsp_last
);

   localparam int NSLOT = SLOTS_PER_PAGE_N * PAGE_COUNT;
   localparam int SW = $clog2(NSLOT);
   localparam int FW = $clog2(NSLOT + 1);
   localparam int WW = SW + 3;
   localparam logic [SW-1:0] S_IDX = SW'(SLOTS_PER_PAGE_N);
   localparam logic [SW-1:0] LAST_IDX = SW'(NSLOT - 1);
   localparam logic [SW-1:0] PAGE_STEPS = SW'(SLOTS_PER_PAGE_N - 1);
   localparam logic [FW-1:0] NSLOT_F = FW'(NSLOT);
   localparam logic [WW-1:0] NSLOT_W = WW'(NSLOT);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_PLAN = 2'd2;

   // slot table
   logic [NSLOT-1:0] erased_ff, valid_ff, magic_ff, ver_ff;
   logic [31:0]      seq_mem [NSLOT];

   // record state
   logic          have_cur_ff, have_cur_in;
   logic [SW-1:0] cur_slot_ff, cur_slot_in;
   logic [31:0]   cur_seq_ff, cur_seq_in;
   logic [SW-1:0] pend_slot_ff, pend_slot_in;
   logic [31:0]   pend_seq_ff, pend_seq_in;

   // sequencer
   logic [1:0]    state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          found_ff, found_in;
   logic [SW-1:0] best_ff, best_in;
   logic [31:0]   bseq_ff, bseq_in;
   logic          best_er_ff, best_er_in;
   logic          mag_ff, mag_in;
   logic          magver_ff, magver_in;
   logic [FW-1:0] free_ff, free_in;
   logic          d0_ff, d0_in, d1_ff, d1_in, crowd_ff, crowd_in;
   logic [2:0]    plan_ff, plan_in;
   logic          pa_ff, pa_in, pc_ff, pc_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [3:0]    rsp_status_ff, rsp_status_in;
   logic [1:0]    rsp_command_ff, rsp_command_in;
   logic [2:0]    rsp_slot_ff, rsp_slot_in;
   logic          rsp_page_ff, rsp_page_in;
   logic [31:0]   rsp_seq_ff, rsp_seq_in;
   logic [2:0]    rsp_free_ff, rsp_free_in;
   logic          rsp_nc_ff, rsp_nc_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          accept;
   logic [WW-1:0] scan_wide;
   logic [SW-1:0] scan_idx;
   logic          scan_ok;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign scan_wide = {{SW{1'b0}}, req_slot_index};
   assign scan_idx  = scan_wide[SW-1:0];
   assign scan_ok   = (scan_wide < NSLOT_W);

   // slot index to the 3-bit result field
   function automatic logic [2:0] slot3(input logic [SW-1:0] s);
      logic [WW-1:0] w;
      w = {3'b000, s};
      return w[2:0];
   endfunction

   // next-state logic of the sequencer and the shared compare/count step
   always_comb begin
      logic          v, e;
      logic [31:0]   sq, diff;
      logic          newer;
      logic [FW-1:0] nonerased;
      logic [WW-1:0] fx;
      logic          oth, curpg, pg;
      logic [2:0]    rest;

      state_in = state_ff;  op_in = op_ff;  idx_in = idx_ff;  cnt_in = cnt_ff;
      found_in = found_ff;  best_in = best_ff;  bseq_in = bseq_ff;
      best_er_in = best_er_ff;  mag_in = mag_ff;  magver_in = magver_ff;
      free_in = free_ff;  d0_in = d0_ff;  d1_in = d1_ff;  crowd_in = crowd_ff;
      plan_in = plan_ff;  pa_in = pa_ff;  pc_in = pc_ff;
      have_cur_in = have_cur_ff;  cur_slot_in = cur_slot_ff;  cur_seq_in = cur_seq_ff;
      pend_slot_in = pend_slot_ff;  pend_seq_in = pend_seq_ff;
      rsp_valid_in = 1'b0;  rsp_status_in = ST_DONE;  rsp_command_in = CMD_NONE;
      rsp_slot_in = 3'd0;  rsp_page_in = 1'b0;  rsp_seq_in = 32'd0;
      rsp_free_in = 3'd0;  rsp_nc_in = 1'b0;  rsp_last_in = 1'b0;

      v = valid_ff[idx_ff];
      e = erased_ff[idx_ff];
      sq = seq_mem[idx_ff];
      diff = sq - bseq_ff;
      newer = !found_ff || ((diff != 32'd0) && !diff[31]);
      pg = (idx_ff >= S_IDX);
      curpg = (cur_slot_ff >= S_IDX);
      oth = !curpg;
      nonerased = '0;
      fx = '0;
      rest = 3'd0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_type;
               case (req_type)
                  REQ_SCAN: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in = 1'b1;
                  end
                  REQ_RESOLVE, REQ_COMPACT: begin
                     idx_in = '0;  cnt_in = LAST_IDX;
                     found_in = 1'b0;  mag_in = 1'b0;  magver_in = 1'b0;
                     free_in = '0;  best_in = '0;  bseq_in = '0;  best_er_in = 1'b0;
                     d0_in = 1'b0;  d1_in = 1'b0;  crowd_in = 1'b0;
                     state_in = S_WALK;
                  end
                  REQ_SAVE: begin
                     if (have_cur_ff && req_same_as_current) begin
                        rsp_valid_in = 1'b1;  rsp_last_in = 1'b1;
                        rsp_status_in = ST_UNCHANGED;
                        rsp_slot_in = slot3(cur_slot_ff);
                        rsp_seq_in = cur_seq_ff;
                     end else begin
                        if (!have_cur_ff || cur_slot_ff == LAST_IDX)
                           idx_in = '0;
                        else
                           idx_in = cur_slot_ff + SW'(1);
                        cnt_in = LAST_IDX;
                        state_in = S_WALK;
                     end
                  end
                  REQ_COMMIT: begin
                     rsp_valid_in = 1'b1;  rsp_last_in = 1'b1;
                     rsp_slot_in = slot3(pend_slot_ff);
                     rsp_seq_in = pend_seq_ff;
                     if (req_write_ok) begin
                        rsp_status_in = ST_WRITTEN;
                        have_cur_in = 1'b1;
                        cur_slot_in = pend_slot_ff;
                        cur_seq_in = pend_seq_ff;
                     end else begin
                        rsp_status_in = ST_FAILED;
                     end
                  end
                  REQ_ERASED: begin
                     idx_in = req_page_index ? S_IDX : '0;
                     cnt_in = PAGE_STEPS;
                     state_in = S_WALK;
                  end
                  default: begin
                     op_in = op_ff;
                  end
               endcase
            end
         end

         S_WALK: begin
            cnt_in = cnt_ff - SW'(1);
            idx_in = idx_ff + SW'(1);
            case (op_ff)
               REQ_RESOLVE: begin
                  if (v && newer) begin
                     found_in = 1'b1;  best_in = idx_ff;  bseq_in = sq;  best_er_in = e;
                  end
                  if (!mag_ff && magic_ff[idx_ff]) begin
                     mag_in = 1'b1;  magver_in = ver_ff[idx_ff];
                  end
                  if (e) free_in = free_ff + FW'(1);
                  if (cnt_ff == '0) begin
                     state_in = S_IDLE;
                     have_cur_in = found_in;
                     nonerased = NSLOT_F - free_in;
                     fx = {{(WW-FW){1'b0}}, free_in};
                     rsp_valid_in = 1'b1;  rsp_last_in = 1'b1;
                     rsp_free_in = (fx > WW'(7)) ? 3'd7 : fx[2:0];
                     if (found_in) begin
                        cur_slot_in = best_in;  cur_seq_in = bseq_in;
                        rsp_status_in = ST_CURRENT;
                        rsp_slot_in = slot3(best_in);
                        rsp_seq_in = bseq_in;
                        rsp_nc_in = (nonerased - (best_er_in ? FW'(0) : FW'(1))) != '0;
                     end else begin
                        rsp_nc_in = (nonerased != '0);
                        if (mag_in)
                           rsp_status_in = magver_in ? ST_CORRUPT : ST_STALE;
                        else
                           rsp_status_in = ST_EMPTY;
                     end
                  end
               end
               REQ_SAVE: begin
                  if (idx_ff == LAST_IDX) idx_in = '0;
                  if (e) begin
                     state_in = S_IDLE;
                     pend_slot_in = idx_ff;
                     pend_seq_in = have_cur_ff ? (cur_seq_ff + 32'd1) : 32'd1;
                     rsp_valid_in = 1'b1;  rsp_last_in = 1'b1;
                     rsp_status_in = ST_PROGRAM;
                     rsp_slot_in = slot3(idx_ff);
                     rsp_seq_in = pend_seq_in;
                  end else if (cnt_ff == '0) begin
                     state_in = S_IDLE;
                     rsp_valid_in = 1'b1;  rsp_last_in = 1'b1;
                     rsp_status_in = ST_FULL;
                  end
               end
               REQ_ERASED: begin
                  if (have_cur_ff && cur_slot_ff == idx_ff) have_cur_in = 1'b0;
                  if (cnt_ff == '0) begin
                     state_in = S_IDLE;
                     rsp_valid_in = 1'b1;  rsp_last_in = 1'b1;
                  end
               end
               default: begin
                  // compaction survey
                  if (!e) begin
                     if (pg) d1_in = 1'b1;
                     else d0_in = 1'b1;
                     if (have_cur_ff && idx_ff != cur_slot_ff && pg == curpg)
                        crowd_in = 1'b1;
                  end
                  if (cnt_ff == '0) begin
                     if (!have_cur_ff) begin
                        pa_in = 1'b0;  pc_in = 1'b1;
                        plan_in = {d1_in, 1'b0, d0_in};
                     end else begin
                        pa_in = oth;  pc_in = curpg;
                        plan_in = {crowd_in, crowd_in, oth ? d1_in : d0_in};
                        if (crowd_in) begin
                           pend_slot_in = oth ? S_IDX : '0;
                           pend_seq_in = cur_seq_ff + 32'd1;
                        end
                     end
                     if (plan_in == 3'd0) begin
                        state_in = S_IDLE;
                        rsp_valid_in = 1'b1;  rsp_last_in = 1'b1;
                     end else begin
                        state_in = S_PLAN;
                     end
                  end
               end
            endcase
         end

         S_PLAN: begin
            rsp_valid_in = 1'b1;
            if (plan_ff[0]) begin
               rest = {plan_ff[2:1], 1'b0};
               rsp_command_in = CMD_ERASE;  rsp_page_in = pa_ff;
            end else if (plan_ff[1]) begin
               rest = {plan_ff[2], 2'b00};
               rsp_command_in = CMD_PROGRAM;  rsp_status_in = ST_PROGRAM;
               rsp_slot_in = slot3(pend_slot_ff);  rsp_seq_in = pend_seq_ff;
            end else begin
               rest = 3'd0;
               rsp_command_in = CMD_ERASE;  rsp_page_in = pc_ff;
            end
            plan_in = rest;
            rsp_last_in = (rest == 3'd0);
            if (rest == 3'd0) state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         have_cur_ff <= 1'b0;
         cur_slot_ff <= '0;
         cur_seq_ff <= '0;
         pend_slot_ff <= '0;
         pend_seq_ff <= '0;
         plan_ff <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         have_cur_ff <= have_cur_in;
         cur_slot_ff <= cur_slot_in;
         cur_seq_ff <= cur_seq_in;
         pend_slot_ff <= pend_slot_in;
         pend_seq_ff <= pend_seq_in;
         plan_ff <= plan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk scratch and result payload
   always_ff @(posedge clock) begin
      op_ff <= op_in;  idx_ff <= idx_in;  cnt_ff <= cnt_in;
      found_ff <= found_in;  best_ff <= best_in;  bseq_ff <= bseq_in;
      best_er_ff <= best_er_in;  mag_ff <= mag_in;  magver_ff <= magver_in;
      free_ff <= free_in;  d0_ff <= d0_in;  d1_ff <= d1_in;  crowd_ff <= crowd_in;
      pa_ff <= pa_in;  pc_ff <= pc_in;
      rsp_status_ff <= rsp_status_in;  rsp_command_ff <= rsp_command_in;
      rsp_slot_ff <= rsp_slot_in;  rsp_page_ff <= rsp_page_in;
      rsp_seq_ff <= rsp_seq_in;  rsp_free_ff <= rsp_free_in;
      rsp_nc_ff <= rsp_nc_in;  rsp_last_ff <= rsp_last_in;
   end

   // slot flags: scan, commit and page-erase writes
   always_ff @(posedge clock) begin
      if (reset) begin
         erased_ff <= '1;
         valid_ff <= '0;
         magic_ff <= '0;
         ver_ff <= '0;
      end else if (accept && req_type == REQ_SCAN && scan_ok) begin
         erased_ff[scan_idx] <= req_is_erased;
         valid_ff[scan_idx] <= req_is_valid;
         magic_ff[scan_idx] <= req_has_magic;
         ver_ff[scan_idx] <= req_version_match;
      end else if (accept && req_type == REQ_COMMIT) begin
         erased_ff[pend_slot_ff] <= 1'b0;
         valid_ff[pend_slot_ff] <= req_write_ok;
         magic_ff[pend_slot_ff] <= req_write_ok;
         ver_ff[pend_slot_ff] <= req_write_ok;
      end else if (state_ff == S_WALK && op_ff == REQ_ERASED) begin
         erased_ff[idx_ff] <= 1'b1;
         valid_ff[idx_ff] <= 1'b0;
         magic_ff[idx_ff] <= 1'b0;
         ver_ff[idx_ff] <= 1'b0;
      end
   end

   // slot sequence numbers, only used where the slot is valid
   always_ff @(posedge clock) begin
      if (accept && req_type == REQ_SCAN && scan_ok)
         seq_mem[scan_idx] <= req_seq_in;
      else if (accept && req_type == REQ_COMMIT && req_write_ok)
         seq_mem[pend_slot_ff] <= pend_seq_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_command = rsp_command_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_page_out = rsp_page_ff;
   assign rsp_seq_out = rsp_seq_ff;
   assign rsp_free_count = rsp_free_ff;
   assign rsp_needs_compact = rsp_nc_ff;
   assign rsp_last = rsp_last_ff;

   `FRLSM_ASSERT_NEXT(a_multi_continues, rsp_valid && !rsp_last, rsp_valid, "result train broke")
   `FRLSM_ASSERT_NEXT(a_item_progresses, accept && req_type <= REQ_COMPACT, busy || rsp_valid, "item dropped")
   `FRLSM_ASSERT(a_plan_nonempty, state_ff == S_PLAN, plan_ff != 3'd0, "empty compaction plan")

endmodule
